// ===== hw/rtl/sjts_pkg.sv =====
// shared constants, types and state codes for the shortest job tick scheduler
package sjts_pkg;

    // table size and clock width
    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    // fixed field widths of the channels
    localparam int SLOT_FIELD_BITS = 4;
    localparam int WORK_BITS       = 16;
    localparam int OUT_TIME_BITS   = 16;
    localparam int SUM_BITS        = ((TIME_BITS > WORK_BITS) ? TIME_BITS : WORK_BITS) + 1;

    typedef logic [TIME_BITS-1:0]       time_t;
    typedef logic [SLOT_BITS-1:0]       slot_t;
    typedef logic [SLOT_FIELD_BITS-1:0] slot_field_t;
    typedef logic [WORK_BITS-1:0]       work_t;
    typedef logic [OUT_TIME_BITS-1:0]   out_time_t;
    typedef logic [SUM_BITS-1:0]        sum_t;

    localparam time_t TIME_MAX  = '1;
    localparam slot_t LAST_SLOT = slot_t'(MAX_JOBS - 1);

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/sjts_if.sv =====
// valid/ready channel interfaces for job items and scheduler results

interface sjts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    sjts_pkg::slot_field_t       slot;
    logic [15:0]                 arrival_time;
    logic [15:0]                 burst_length;

    modport source (output valid, kind, slot, arrival_time, burst_length, input ready);
    modport sink   (input valid, kind, slot, arrival_time, burst_length, output ready);
endinterface

interface sjts_out_if;
    logic                        valid;
    logic                        ready;
    logic                        running;
    sjts_pkg::slot_field_t       run_slot;
    logic [15:0]                 time_now;
    logic                        finished;
    logic [15:0]                 wait_time;
    logic                        all_done;

    modport source (output valid, running, run_slot, time_now, finished, wait_time, all_done,
                    input ready);
    modport sink   (input valid, running, run_slot, time_now, finished, wait_time, all_done,
                    output ready);
endinterface

// ===== hw/rtl/shortest_job_tick_scheduler.sv =====
// shortest remaining time first scheduler over a table of job slots
//
//   channel   direction  content
//   in_ch     in         kind, slot, arrival_time, burst_length
//   out_ch    out        running, run_slot, time_now, finished, wait_time, all_done
//   cfg       in         cfg_wr_en / cfg_wr_data: preemptive mode bit
//
// a load item passes the load and emit states; a tick item passes the scan, scan end,
// update and emit states, the scan reading one slot a cycle from the tables through one
// compare unit. reset clears the valid bits, clock and running mark; the tables
// themselves need no clearing. a new item is taken while a result still waits; the load
// and update steps hold until the previous result has left on out_ch.
module shortest_job_tick_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    sjts_in_if.sink     in_ch,
    sjts_out_if.source  out_ch,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import sjts_pkg::*;

    // job tables, no reset: entries with a clear valid bit are never used
    time_t arr_mem   [MAX_JOBS];
    work_t burst_mem [MAX_JOBS];
    work_t rem_mem   [MAX_JOBS];

    state_t state_reg, state_next;

    logic [MAX_JOBS-1:0] live_reg, live_next;
    time_t clock_reg, clock_next;
    slot_t cur_slot_reg, cur_slot_next;
    logic  cur_valid_reg, cur_valid_next;
    logic  preempt_reg;

    // captured item
    logic        item_kind_reg;
    slot_field_t item_slot_reg;
    time_t       item_arr_reg;
    work_t       item_burst_reg;
    logic        forced_reg;

    // scan pipeline
    slot_t idx_reg;
    logic  rd_vld_reg;
    slot_t rd_idx_reg;
    time_t rd_arr_reg;
    work_t rd_burst_reg;
    work_t rd_rem_reg;

    // best candidate so far
    logic  best_found_reg;
    slot_t best_slot_reg;
    work_t best_rem_reg;
    time_t best_arr_reg;
    work_t best_burst_reg;

    // result stage
    logic        out_valid_reg;
    logic        res_running_reg, res_running_next;
    slot_field_t res_slot_reg, res_slot_next;
    out_time_t   res_time_reg, res_time_next;
    logic        res_finished_reg, res_finished_next;
    out_time_t   res_wait_reg, res_wait_next;
    logic        res_all_done_reg, res_all_done_next;

    // memory write port
    logic  wr_en;
    logic  wr_load;
    slot_t wr_addr;
    work_t wr_rem;

    logic  in_xfer;
    logic  out_xfer;
    logic  emit_go;
    logic  slot_ok;
    slot_t load_idx;
    time_t clock_inc;
    work_t rem_dec;
    sum_t  used_sum;
    sum_t  clock_ext;
    logic  cand;
    logic  better;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_xfer     = out_valid_reg && out_ch.ready;
    assign emit_go      = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.running   = res_running_reg;
    assign out_ch.run_slot  = res_slot_reg;
    assign out_ch.time_now  = res_time_reg;
    assign out_ch.finished  = res_finished_reg;
    assign out_ch.wait_time = res_wait_reg;
    assign out_ch.all_done  = res_all_done_reg;

    assign slot_ok   = (32'(item_slot_reg) < 32'(MAX_JOBS));
    assign load_idx  = slot_t'(item_slot_reg);
    assign clock_inc = (clock_reg == TIME_MAX) ? clock_reg : clock_reg + time_t'(1);
    assign rem_dec   = best_rem_reg - work_t'(1);
    assign used_sum  = sum_t'(best_arr_reg) + sum_t'(best_burst_reg);
    assign clock_ext = sum_t'(clock_inc);

    // shared compare unit: one table entry against the best so far
    always_comb
    begin
        if (forced_reg)
            cand = (rd_idx_reg == cur_slot_reg);
        else
            cand = live_reg[rd_idx_reg] && (rd_arr_reg <= clock_reg);
        better = !best_found_reg
              || (rd_rem_reg < best_rem_reg)
              || ((rd_rem_reg == best_rem_reg) && (rd_arr_reg < best_arr_reg));
    end

    // sequencer: next state, state updates and result
    always_comb
    begin
        state_next        = state_reg;
        live_next         = live_reg;
        clock_next        = clock_reg;
        cur_slot_next     = cur_slot_reg;
        cur_valid_next    = cur_valid_reg;
        res_running_next  = res_running_reg;
        res_slot_next     = res_slot_reg;
        res_time_next     = res_time_reg;
        res_finished_next = res_finished_reg;
        res_wait_next     = res_wait_reg;
        res_all_done_next = res_all_done_reg;
        wr_en             = 1'b0;
        wr_load           = 1'b0;
        wr_addr           = best_slot_reg;
        wr_rem            = rem_dec;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_ch.kind == KIND_LOAD)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_LOAD:
            begin
                // wait until the result registers are free
                if (emit_go)
                begin
                    if (slot_ok)
                    begin
                        wr_en     = 1'b1;
                        wr_load   = 1'b1;
                        wr_addr   = load_idx;
                        wr_rem    = item_burst_reg;
                        live_next[load_idx] = (item_burst_reg != '0);
                        if (cur_valid_reg && (cur_slot_reg == load_idx))
                            cur_valid_next = 1'b0;
                    end
                    res_running_next  = 1'b0;
                    res_slot_next     = '0;
                    res_time_next     = out_time_t'(clock_reg);
                    res_finished_next = 1'b0;
                    res_wait_next     = '0;
                    res_all_done_next = ~|live_next;
                    state_next        = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_SLOT)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // wait until the result registers are free
                if (emit_go)
                begin
                    clock_next        = clock_inc;
                    res_time_next     = out_time_t'(clock_inc);
                    res_finished_next = 1'b0;
                    res_wait_next     = '0;
                    if (best_found_reg)
                    begin
                        wr_en            = 1'b1;
                        res_running_next = 1'b1;
                        res_slot_next    = slot_field_t'(best_slot_reg);
                        cur_slot_next    = best_slot_reg;
                        cur_valid_next   = (rem_dec != '0);
                        if (rem_dec == '0)
                        begin
                            live_next[best_slot_reg] = 1'b0;
                            res_finished_next        = 1'b1;
                            if (clock_ext > used_sum)
                                res_wait_next = out_time_t'(clock_ext - used_sum);
                        end
                    end
                    else
                    begin
                        res_running_next = 1'b0;
                        res_slot_next    = '0;
                        cur_valid_next   = 1'b0;
                    end
                    res_all_done_next = ~|live_next;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            clock_reg     <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            preempt_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            clock_reg     <= clock_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            if (cfg_wr_en)
                preempt_reg <= cfg_wr_data;
            // result stage handoff
            if (state_reg == ST_EMIT && emit_go)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            rd_vld_reg <= (state_reg == ST_SCAN);
            // best candidate tracking
            if (in_xfer)
                best_found_reg <= 1'b0;
            else if (rd_vld_reg && cand && better)
                best_found_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_running_reg  <= res_running_next;
        res_slot_reg     <= res_slot_next;
        res_time_reg     <= res_time_next;
        res_finished_reg <= res_finished_next;
        res_wait_reg     <= res_wait_next;
        res_all_done_reg <= res_all_done_next;
        // item capture on input transfer
        if (in_xfer)
        begin
            item_kind_reg  <= in_ch.kind;
            item_slot_reg  <= in_ch.slot;
            item_arr_reg   <= time_t'(in_ch.arrival_time);
            item_burst_reg <= work_t'(in_ch.burst_length);
            forced_reg     <= !preempt_reg && cur_valid_reg && live_reg[cur_slot_reg]
                              && (in_ch.kind == KIND_TICK);
            idx_reg        <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + slot_t'(1);
        end
        // winner of each compare
        if (rd_vld_reg && cand && better)
        begin
            best_slot_reg  <= rd_idx_reg;
            best_rem_reg   <= rd_rem_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
        end
    end

    // table read port, one slot per scan cycle
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= idx_reg;
        rd_arr_reg   <= arr_mem[idx_reg];
        rd_burst_reg <= burst_mem[idx_reg];
        rd_rem_reg   <= rem_mem[idx_reg];
    end

    // table write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rem_mem[wr_addr] <= wr_rem;
            if (wr_load && item_kind_reg == KIND_LOAD)
            begin
                arr_mem[wr_addr]   <= item_arr_reg;
                burst_mem[wr_addr] <= item_burst_reg;
            end
        end
    end

endmodule

// ===== test/shortest_job_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the shortest job tick scheduler: directed table, random job batches
module shortest_job_tick_scheduler_tb;
    import sjts_pkg::*;

    localparam logic MODE_NON_PREEMPT = 1'b0;
    localparam logic MODE_PREEMPT     = 1'b1;
    localparam int   RANDOM_ITEMS     = 730;
    localparam int   CYCLE_LIMIT      = 4_000_000;
    localparam int   SETTLE_CYCLES    = 2 * MAX_JOBS + 8;
    localparam int   REPORT_LIMIT     = 10;
    localparam int   IDLE_PCT         = 29;
    localparam int   BATCH_GUARD      = 200;

    typedef struct packed {
        logic        kind;
        slot_field_t slot;
        logic [15:0] arrival;
        logic [15:0] burst;
    } job_item_t;

    typedef struct packed {
        logic        running;
        slot_field_t run_slot;
        logic [15:0] time_now;
        logic        finished;
        logic [15:0] wait_time;
        logic        all_done;
    } sched_result_t;

    typedef struct packed {
        job_item_t     item;
        logic          typed;
        sched_result_t want;
    } dir_row_t;

    localparam sched_result_t NO_RESULT = '0;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    sjts_in_if  in_ch ();
    sjts_out_if out_ch ();

    shortest_job_tick_scheduler uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // scheduler state as predicted from accepted items
    logic [15:0] job_arrival [MAX_JOBS];
    logic [15:0] job_burst   [MAX_JOBS];
    logic [15:0] job_left    [MAX_JOBS];
    logic [15:0] sched_clock;
    int          held_slot;
    logic        held_valid;
    logic        sched_mode;

    sched_result_t pending_results [$];
    dir_row_t      step_table [$];

    bit no_idle = 1'b0;
    int cycle_count       = 0;
    int mismatch_count    = 0;
    int items_sent        = 0;
    int load_count        = 0;
    int tick_count        = 0;
    int busy_count        = 0;
    int finish_count      = 0;
    int late_finish_count = 0;
    int mode_writes       = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one item to the predicted state and return the result it causes
    function automatic sched_result_t schedule_step(input job_item_t it);
        sched_result_t res;
        int            pick;
        int            waited;
        int            i;
        res  = '0;
        pick = -1;
        if (it.kind == KIND_LOAD)
        begin
            job_arrival[it.slot] = it.arrival;
            job_burst[it.slot]   = it.burst;
            job_left[it.slot]    = it.burst;
            if (held_valid && held_slot == int'(it.slot))
                held_valid = 1'b0;
            load_count++;
        end
        else
        begin
            tick_count++;
            // non-preemptive mode keeps the started job
            if (sched_mode == MODE_NON_PREEMPT && held_valid && job_left[held_slot] != 0)
                pick = held_slot;
            else
            begin
                for (i = 0; i < MAX_JOBS; i++)
                begin
                    if (job_left[i] != 0 && job_arrival[i] <= sched_clock)
                    begin
                        if (pick < 0 || job_left[i] < job_left[pick] ||
                            (job_left[i] == job_left[pick] && job_arrival[i] < job_arrival[pick]))
                            pick = i;
                    end
                end
            end
            if (sched_clock != TIME_MAX)
                sched_clock++;
            if (pick >= 0)
            begin
                busy_count++;
                res.running  = 1'b1;
                res.run_slot = slot_field_t'(pick);
                job_left[pick]--;
                held_slot  = pick;
                held_valid = 1'b1;
                if (job_left[pick] == 0)
                begin
                    // negative wait only happens with a saturated clock
                    waited = int'(sched_clock) - int'(job_arrival[pick]) - int'(job_burst[pick]);
                    res.finished  = 1'b1;
                    res.wait_time = (waited > 0) ? waited[15:0] : 16'd0;
                    held_valid    = 1'b0;
                    finish_count++;
                    if (sched_clock == TIME_MAX)
                        late_finish_count++;
                end
            end
            else
                held_valid = 1'b0;
        end
        res.time_now = sched_clock;
        res.all_done = 1'b1;
        for (i = 0; i < MAX_JOBS; i++)
            if (job_left[i] != 0)
                res.all_done = 1'b0;
        return res;
    endfunction

    // any unfinished job outside the parked slots
    function automatic bit work_pending(input logic [MAX_JOBS-1:0] parked);
        int i;
        for (i = 0; i < MAX_JOBS; i++)
            if (!parked[i] && job_left[i] != 0)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // present one item, hold it until the transfer, then record what it should produce
    task automatic send_item(input job_item_t it, input logic typed, input sched_result_t typed_res);
        sched_result_t predicted;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= it.kind;
        in_ch.slot         <= it.slot;
        in_ch.arrival_time <= it.arrival;
        in_ch.burst_length <= it.burst;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = schedule_step(it);
        pending_results.push_back(typed ? typed_res : predicted);
        items_sent++;
    endtask

    // mode register write once every result is back
    task automatic set_mode(input logic mode);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sched_mode = mode;
        mode_writes++;
    endtask

    // a batch of jobs arriving soon, run until done or the guard limit, with noise loads parked and cleared
    task automatic run_job_batch();
        int                  jobs_to_load;
        int                  guard;
        int                  roll;
        int                  s;
        logic [MAX_JOBS-1:0] parked;
        job_item_t           it;
        jobs_to_load = $urandom_range(1, 6);
        guard        = 0;
        parked       = '0;
        while ((jobs_to_load > 0 || work_pending(parked)) && guard < BATCH_GUARD)
        begin
            guard++;
            roll       = $urandom_range(0, 99);
            it.kind    = KIND_TICK;
            it.slot    = slot_field_t'($urandom_range(0, 15));
            it.arrival = 16'($urandom_range(0, 65535));
            it.burst   = 16'($urandom_range(0, 65535));
            if (roll >= 93)
            begin
                it.kind        = KIND_LOAD;
                parked[it.slot] = 1'b1;
            end
            else if (jobs_to_load > 0 && (roll < 35 || !work_pending(parked)))
            begin
                it.kind    = KIND_LOAD;
                it.arrival = sched_clock + 16'($urandom_range(0, 5));
                it.burst   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 30))
                                                        : 16'($urandom_range(1, 6));
                parked[it.slot] = 1'b0;
                jobs_to_load--;
            end
            send_item(it, 1'b0, NO_RESULT);
            // mode flips while a job may hold the running mark
            if ($urandom_range(0, 99) < 3)
                set_mode(logic'($urandom_range(0, 1)));
        end
        for (s = 0; s < MAX_JOBS; s++)
        begin
            if (parked[s])
            begin
                it.kind    = KIND_LOAD;
                it.slot    = slot_field_t'(s);
                it.arrival = 16'($urandom_range(0, 65535));
                it.burst   = 16'd0;
                send_item(it, 1'b0, NO_RESULT);
            end
        end
    endtask

    // result check, receiver stalls and run limit
    always @(posedge clk)
    begin : result_check
        sched_result_t want_res;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result transfer with nothing outstanding", $time);
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("running",   16'(want_res.running),  16'(out_ch.running));
                check_field("run_slot",  16'(want_res.run_slot), 16'(out_ch.run_slot));
                check_field("time_now",  want_res.time_now,      out_ch.time_now);
                check_field("finished",  16'(want_res.finished), 16'(out_ch.finished));
                check_field("wait_time", want_res.wait_time,     out_ch.wait_time);
                check_field("all_done",  16'(want_res.all_done), 16'(out_ch.all_done));
            end
        end
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // stimulus
    initial
    begin : stimulus
        job_item_t it;
        int        i;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_LOAD;
        in_ch.slot         = '0;
        in_ch.arrival_time = '0;
        in_ch.burst_length = '0;
        out_ch.ready       = 1'b0;
        for (i = 0; i < MAX_JOBS; i++)
        begin
            job_arrival[i] = '0;
            job_burst[i]   = '0;
            job_left[i]    = '0;
        end
        sched_clock = '0;
        held_slot   = 0;
        held_valid  = 1'b0;
        sched_mode  = MODE_PREEMPT;

        // empty table: tick is idle, clock still moves
        step_table.push_back(dir_row_t'({KIND_TICK, 4'd0, 16'h0000, 16'h0000,
                                         1'b1, 1'b0, 4'd0, 16'd1, 1'b0, 16'd0, 1'b1}));
        // largest job in the top slot, arriving at the last tick
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF,
                                         1'b1, 1'b0, 4'd0, 16'd1, 1'b0, 16'd0, 1'b0}));
        // job not yet arrived: idle tick
        step_table.push_back(dir_row_t'({KIND_TICK, 4'd0, 16'h0000, 16'h0000,
                                         1'b1, 1'b0, 4'd0, 16'd2, 1'b0, 16'd0, 1'b0}));
        // zero burst empties the slot
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd15, 16'h0000, 16'h0000,
                                         1'b1, 1'b0, 4'd0, 16'd2, 1'b0, 16'd0, 1'b1}));
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd0, 16'h0000, 16'h0001,
                                         1'b1, 1'b0, 4'd0, 16'd2, 1'b0, 16'd0, 1'b0}));
        // one-tick job finishes with wait 3 - 0 - 1
        step_table.push_back(dir_row_t'({KIND_TICK, 4'd0, 16'h0000, 16'h0000,
                                         1'b1, 1'b1, 4'd0, 16'd3, 1'b1, 16'd2, 1'b1}));
        // equal remaining time: earlier arrival first, then lower slot
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd3, 16'd3, 16'd3, 1'b0, NO_RESULT}));
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd5, 16'd3, 16'd2, 1'b0, NO_RESULT}));
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd9, 16'd1, 16'd2, 1'b0, NO_RESULT}));
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd6, 16'd1, 16'd2, 1'b0, NO_RESULT}));
        step_table.push_back(dir_row_t'({KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0, NO_RESULT}));
        // reload of the running slot drops its running mark
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd6, 16'd4, 16'd1, 1'b0, NO_RESULT}));
        for (i = 0; i < 9; i++)
            step_table.push_back(dir_row_t'({KIND_TICK, 4'hF, 16'hFFFF, 16'hFFFF,
                                             1'b0, NO_RESULT}));
        step_table.push_back(dir_row_t'({KIND_LOAD, 4'd10, 16'hFFFF, 16'h0000, 1'b0, NO_RESULT}));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (step_table[i])
            send_item(step_table[i].item, step_table[i].typed, step_table[i].want);

        // random job batches under both modes
        set_mode(MODE_NON_PREEMPT);
        while (items_sent < step_table.size() + RANDOM_ITEMS)
        begin
            no_idle = (items_sent >= 300 && items_sent < 450);
            if ($urandom_range(0, 99) < 15)
                set_mode(logic'($urandom_range(0, 1)));
            run_job_batch();
        end

        // clear leftover jobs, then an old arrival finishing late gives a wide wait
        no_idle = 1'b1;
        set_mode(MODE_PREEMPT);
        for (i = 0; i < MAX_JOBS; i++)
        begin
            if (job_left[i] != 0)
            begin
                it.kind    = KIND_LOAD;
                it.slot    = slot_field_t'(i);
                it.arrival = 16'($urandom_range(0, 65535));
                it.burst   = 16'd0;
                send_item(it, 1'b0, NO_RESULT);
            end
        end
        it.kind    = KIND_LOAD;
        it.slot    = 4'd3;
        it.arrival = 16'd0;
        it.burst   = 16'd1;
        send_item(it, 1'b0, NO_RESULT);
        it.kind = KIND_TICK;
        send_item(it, 1'b0, NO_RESULT);
        send_item(it, 1'b0, NO_RESULT);

        // drain and settle
        in_ch.valid <= 1'b0;
        no_idle = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d loads and %0d ticks (%0d busy, %0d idle), %0d jobs completed",
                 load_count, tick_count, busy_count, tick_count - busy_count, finish_count);
        $display("%0d mode register writes, %0d completions at the saturated clock",
                 mode_writes, late_finish_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sjts_pkg.sv
hw/rtl/sjts_if.sv
hw/rtl/shortest_job_tick_scheduler.sv
test/shortest_job_tick_scheduler_tb.sv
